### design/ecc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg: shared types and constants of the elevator car controller
// Field widths, operation, mode and sequencer codes, and the cell control beat.
// ----------------------------------------------------------------------------
package ecc_pkg;

    localparam int FLOOR_W   = 4;
    localparam int CFG_W     = 16;
    localparam int MASK_W    = 10;
    localparam int LAMP_W    = 10;
    localparam int OP_W      = 2;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam int NUM_FLOORS_DEF = 10;
    localparam int TIMER_BITS_DEF = 16;
    localparam int HOME_RST_DEF   = 3;

    localparam logic [CFG_W-1:0] MOVE_TIME_RST = 16'd3000;
    localparam logic [CFG_W-1:0] DOOR_TIME_RST = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME      = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_STEP = 2'd1,
        OP_CAB  = 2'd2,
        OP_CALL = 2'd3
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED = 3'd0,
        MODE_RISING  = 3'd1,
        MODE_FALLING = 3'd2,
        MODE_OPENING = 3'd3,
        MODE_CLOSING = 3'd4
    } t_car_mode;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DECIDE,
        SEQ_ARRIVE,
        SEQ_REPORT
    } t_seq_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_CAB,
        CELL_CALL,
        CELL_CLEAR
    } t_cell_op;

    // Broadcast to every cell of the stop chain.
    typedef struct packed {
        t_cell_op             op;
        logic [FLOOR_W-1:0]   home;
        logic [FLOOR_W-1:0]   floor;
    } t_cell_ctrl;

    // One-hot floor lamp; floors outside the lamp field show nothing.
    function automatic logic [LAMP_W-1:0] floor_lamp(input logic [FLOOR_W-1:0] f);
        logic [LAMP_W-1:0] v;
        v = '0;
        for (int i = 0; i < LAMP_W; i++) begin
            if (f == FLOOR_W'(i + 1)) begin
                v[i] = 1'b1;
            end
        end
        return v;
    endfunction

endpackage

### design/elevator_car_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_car_controller: controller for one elevator car
// Stop table in a ring of cells, travel and door timers, lamps and car mode.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+--------------------------------
//  item in   | start, busy (taken: start&!busy)| i_operation, i_call_floor,
//            |                                | i_button_mask
//  result out| o_result_valid, 1-cycle strobe | o_car_state, o_floor_now, lamps,
//            |                                | o_floor_lamps, o_door_open
//  config    | i_cfg_valid, o_cfg_ready       | i_cfg_index, i_cfg_data
//
//  Each beat ends in the report state: tick, cab buttons, hall call and most
//  control steps go there at once; a step that moves the car one floor
//  passes the arrive state first; a step while stopped passes the scan state,
//  where the stop table rotates once past the scan head, one slot per cycle.
//  busy stays high from the accepting edge until the result strobe.
//  Reset is synchronous; all slots load the home floor at once, no sweep.
//  The result is shown for one cycle only; the receiver cannot stall it.
//  o_cfg_ready is always high.
//
module elevator_car_controller
    import ecc_pkg::*;
#(
    parameter int NUM_FLOORS = NUM_FLOORS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item in
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [FLOOR_W-1:0]   i_call_floor,
    input  logic [MASK_W-1:0]    i_button_mask,
    // result out
    output logic                 o_result_valid,
    output logic [MODE_W-1:0]    o_car_state,
    output logic [FLOOR_W-1:0]   o_floor_now,
    output logic                 o_up_lamp,
    output logic                 o_down_lamp,
    output logic [LAMP_W-1:0]    o_floor_lamps,
    output logic                 o_door_open,
    // config
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [FLOOR_W-1:0] HOME_RST =
        (HOME_RST_DEF > NUM_FLOORS) ? FLOOR_W'(NUM_FLOORS) : FLOOR_W'(HOME_RST_DEF);
    localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(NUM_FLOORS);
    localparam int CNT_W  = $clog2(NUM_FLOORS);
    localparam int WIDE_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [CNT_W-1:0]      CNT_LAST  = CNT_W'(NUM_FLOORS - 1);
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    // Configuration
    logic [CFG_W-1:0]   r_move_time;
    logic [CFG_W-1:0]   r_door_time;
    logic [FLOOR_W-1:0] r_home;
    logic [FLOOR_W-1:0] w_home_clamp;

    // Car state
    t_seq_state          r_state,   n_state;
    t_car_mode           r_mode,    n_mode;
    logic [FLOOR_W-1:0]  r_cur,     n_cur;
    logic [FLOOR_W-1:0]  r_target,  n_target;
    logic [TIMER_BITS-1:0] r_travel, n_travel;
    logic [TIMER_BITS-1:0] r_door_tmr, n_door_tmr;
    logic                r_up,      n_up;
    logic                r_down,    n_down;
    logic [LAMP_W-1:0]   r_ind,     n_ind;
    logic                r_door,    n_door;

    // Scan of the stop ring
    logic [FLOOR_W-1:0]  r_max,     n_max;
    logic [FLOOR_W-1:0]  r_min,     n_min;
    logic [CNT_W-1:0]    r_cnt,     n_cnt;

    logic [WIDE_W-1:0]     w_move_wide;
    logic [WIDE_W-1:0]     w_door_wide;
    logic [TIMER_BITS-1:0] w_move_load;
    logic [TIMER_BITS-1:0] w_door_load;

    t_cell_ctrl         w_cell_ctrl;
    logic [FLOOR_W-1:0] w_head;
    logic               w_hit;
    logic               w_call_ok;

    // Timer loads keep TIMER_BITS bits of the setting.
    assign w_move_wide = WIDE_W'(r_move_time);
    assign w_door_wide = WIDE_W'(r_door_time);
    assign w_move_load = w_move_wide[TIMER_BITS-1:0];
    assign w_door_load = w_door_wide[TIMER_BITS-1:0];

    assign w_call_ok = (i_call_floor != '0) && (i_call_floor <= TOP_FLOOR);

    // ------------------------------------------------------------------
    // Configuration port: always ready, home floor clamped to the shaft
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_home_clamp = i_cfg_data[FLOOR_W-1:0];
        if (w_home_clamp == '0) begin
            w_home_clamp = FLOOR_W'(1);
        end else if (w_home_clamp > TOP_FLOOR) begin
            w_home_clamp = TOP_FLOOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_time <= MOVE_TIME_RST;
            r_door_time <= DOOR_TIME_RST;
            r_home      <= HOME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MOVE_TIME: r_move_time <= i_cfg_data;
                CFG_DOOR_TIME: r_door_time <= i_cfg_data;
                CFG_HOME:      r_home      <= w_home_clamp;
                default:       r_home      <= r_home;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stop table: ring of cells, slot 0 at the scan head
    // ------------------------------------------------------------------
    ecc_stop_chain #(
        .NUM_FLOORS (NUM_FLOORS),
        .HOME_RST   (HOME_RST)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_cell_ctrl),
        .i_mask  (i_button_mask),
        .o_head  (w_head),
        .o_hit   (w_hit)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state and cell commands
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_cur      = r_cur;
        n_target   = r_target;
        n_travel   = r_travel;
        n_door_tmr = r_door_tmr;
        n_up       = r_up;
        n_down     = r_down;
        n_ind      = r_ind;
        n_door     = r_door;
        n_max      = r_max;
        n_min      = r_min;
        n_cnt      = r_cnt;

        w_cell_ctrl.op    = CELL_HOLD;
        w_cell_ctrl.home  = r_home;
        w_cell_ctrl.floor = r_cur;

        case (r_state)
            SEQ_IDLE: begin
                if (start) begin
                    n_state = SEQ_REPORT;
                    case (t_op'(i_operation))
                        OP_TICK: begin
                            if (r_travel != '0) begin
                                n_travel = r_travel - TIMER_ONE;
                            end
                            if (r_door_tmr != '0) begin
                                n_door_tmr = r_door_tmr - TIMER_ONE;
                            end
                        end
                        OP_STEP: begin
                            case (r_mode)
                                MODE_RISING: begin
                                    if (r_travel == '0) begin
                                        n_cur   = r_cur + FLOOR_W'(1);
                                        n_up    = 1'b1;
                                        n_down  = 1'b0;
                                        n_state = SEQ_ARRIVE;
                                    end
                                end
                                MODE_FALLING: begin
                                    if (r_travel == '0) begin
                                        n_cur   = r_cur - FLOOR_W'(1);
                                        n_up    = 1'b0;
                                        n_down  = 1'b1;
                                        n_state = SEQ_ARRIVE;
                                    end
                                end
                                MODE_OPENING: begin
                                    n_door = 1'b1;
                                    if (r_door_tmr == '0) begin
                                        n_mode     = MODE_CLOSING;
                                        n_door_tmr = w_door_load;
                                    end
                                end
                                MODE_CLOSING: begin
                                    if (r_door_tmr == '0) begin
                                        n_mode = MODE_STOPPED;
                                        n_door = 1'b0;
                                    end
                                end
                                default: begin
                                    // stopped: sweep the ring for highest and lowest stop
                                    n_max   = r_target;
                                    n_min   = '1;
                                    n_cnt   = '0;
                                    n_state = SEQ_SCAN;
                                end
                            endcase
                        end
                        OP_CAB: begin
                            w_cell_ctrl.op = CELL_CAB;
                        end
                        OP_CALL: begin
                            if (w_call_ok) begin
                                n_mode = MODE_OPENING;
                                // a call at the car's floor only opens the doors
                                if (i_call_floor != r_cur) begin
                                    w_cell_ctrl.op    = CELL_CALL;
                                    w_cell_ctrl.floor = i_call_floor;
                                end
                            end
                        end
                        default: n_state = SEQ_REPORT;
                    endcase
                end
            end
            SEQ_SCAN: begin
                w_cell_ctrl.op = CELL_ROTATE;
                if (w_head > r_max) begin
                    n_max = w_head;
                end
                if (w_head < r_min) begin
                    n_min = w_head;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = SEQ_DECIDE;
                end
            end
            SEQ_DECIDE: begin
                n_state = SEQ_REPORT;
                if (r_max > r_cur) begin
                    n_target = r_max;
                    n_mode   = MODE_RISING;
                    n_travel = w_move_load;
                end else begin
                    // target drops to the lowest stop, at or below the highest
                    n_target = r_min;
                    if (r_min < r_cur) begin
                        n_mode   = MODE_FALLING;
                        n_travel = w_move_load;
                    end else begin
                        n_mode = MODE_STOPPED;
                        n_up   = 1'b0;
                        n_down = 1'b0;
                        n_ind  = floor_lamp(r_cur);
                    end
                end
            end
            SEQ_ARRIVE: begin
                // car stands at the new floor: drop every stop pending here
                w_cell_ctrl.op = CELL_CLEAR;
                n_ind          = floor_lamp(r_cur);
                n_state        = SEQ_REPORT;
                if (r_cur == r_target) begin
                    n_mode = MODE_OPENING;
                end else begin
                    if (w_hit) begin
                        n_mode = MODE_OPENING;
                    end
                    n_travel = w_move_load;
                end
            end
            SEQ_REPORT: begin
                n_state = SEQ_IDLE;
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SEQ_IDLE;
            r_mode     <= MODE_STOPPED;
            r_cur      <= HOME_RST;
            r_target   <= HOME_RST;
            r_travel   <= '0;
            r_door_tmr <= '0;
            r_up       <= 1'b0;
            r_down     <= 1'b0;
            r_ind      <= '0;
            r_door     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_cur      <= n_cur;
            r_target   <= n_target;
            r_travel   <= n_travel;
            r_door_tmr <= n_door_tmr;
            r_up       <= n_up;
            r_down     <= n_down;
            r_ind      <= n_ind;
            r_door     <= n_door;
            r_cnt      <= n_cnt;
        end
    end

    // Scan accumulators are not reset; a stopped step loads them before the scan.
    always_ff @(posedge i_clk) begin
        r_max <= n_max;
        r_min <= n_min;
    end

    assign busy = (r_state != SEQ_IDLE);

    // ------------------------------------------------------------------
    // Result beat: capture the settled state for one cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= (r_state == SEQ_REPORT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SEQ_REPORT) begin
            o_car_state   <= r_mode;
            o_floor_now   <= r_cur;
            o_up_lamp     <= r_up;
            o_down_lamp   <= r_down;
            o_floor_lamps <= r_ind;
            o_door_open   <= r_door;
        end
    end

endmodule

### design/ecc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_cell: one stop slot
// Holds the slot of one floor; rotates, fills or empties it on command.
// ----------------------------------------------------------------------------
module ecc_cell
    import ecc_pkg::*;
#(
    parameter int                 FLOOR_IDX = 0,
    parameter logic [FLOOR_W-1:0] HOME_RST  = FLOOR_W'(HOME_RST_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_mask_bit,
    input  logic [FLOOR_W-1:0] i_shift,
    output logic [FLOOR_W-1:0] o_slot,
    output logic               o_hit
);

    localparam logic [FLOOR_W-1:0] OWN_FLOOR = FLOOR_W'(FLOOR_IDX + 1);

    logic [FLOOR_W-1:0] r_slot;
    logic [FLOOR_W-1:0] n_slot;

    always_comb begin
        n_slot = r_slot;
        case (i_ctrl.op)
            CELL_ROTATE: n_slot = i_shift;
            CELL_CAB: begin
                if (i_mask_bit && (r_slot == i_ctrl.home)) begin
                    n_slot = OWN_FLOOR;
                end
            end
            CELL_CALL: begin
                if (i_ctrl.floor == OWN_FLOOR) begin
                    n_slot = OWN_FLOOR;
                end
            end
            CELL_CLEAR: begin
                if (r_slot == i_ctrl.floor) begin
                    n_slot = i_ctrl.home;
                end
            end
            default: n_slot = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= HOME_RST;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_hit  = (r_slot == i_ctrl.floor);

endmodule

### design/ecc_stop_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_stop_chain: ring of stop slot cells
// Wires the cells into a ring toward slot 0 and gathers the clear hits.
// ----------------------------------------------------------------------------
module ecc_stop_chain
    import ecc_pkg::*;
#(
    parameter int                 NUM_FLOORS = NUM_FLOORS_DEF,
    parameter logic [FLOOR_W-1:0] HOME_RST   = FLOOR_W'(HOME_RST_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctrl         i_ctrl,
    input  logic [MASK_W-1:0]  i_mask,
    output logic [FLOOR_W-1:0] o_head,
    output logic               o_hit
);

    logic [FLOOR_W-1:0]           w_slot [NUM_FLOORS];
    logic [NUM_FLOORS-1:0]        w_hit;
    logic [NUM_FLOORS+MASK_W-1:0] w_mask_pad;

    // Mask bits past the last floor never reach a cell.
    assign w_mask_pad = (NUM_FLOORS + MASK_W)'(i_mask);

    for (genvar g = 0; g < NUM_FLOORS; g++) begin : g_cell
        ecc_cell #(
            .FLOOR_IDX (g),
            .HOME_RST  (HOME_RST)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (i_ctrl),
            .i_mask_bit (w_mask_pad[g]),
            .i_shift    (w_slot[(g + 1) % NUM_FLOORS]),
            .o_slot     (w_slot[g]),
            .o_hit      (w_hit[g])
        );
    end

    assign o_head = w_slot[0];
    assign o_hit  = |w_hit;

endmodule

### design/ecc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_checker: port checks of the elevator car controller
// Timing of result beats against accepted items, and lamp encoding.
// ----------------------------------------------------------------------------
module ecc_checker
    import ecc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [OP_W-1:0]    i_operation,
    input  logic               o_result_valid,
    input  logic [LAMP_W-1:0]  o_floor_lamps
);

    // Items other than a control step go straight to the report state, and the result beat follows it.
    a_short_item_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation != OP_STEP)) |=> ##1 o_result_valid)
        else $error("result beat missing after short item");

    // The block is idle again while its result is shown.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("busy during result beat");

    // A result is a single-cycle strobe.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    // Floor indicator shows at most one floor.
    a_lamp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $onehot0(o_floor_lamps))
        else $error("floor lamps not one-hot");

endmodule

bind elevator_car_controller ecc_checker u_ecc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_result_valid (o_result_valid),
    .o_floor_lamps  (o_floor_lamps)
);

### test/elevator_car_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_car_controller_tb: self-checking bench for the elevator car controller
// Drives ticks, control steps, cab button masks and hall calls, writes move time,
// door time and home floor between phases, and checks every reported car state
// against a cycle-free model of the car kept inside the bench.
// ----------------------------------------------------------------------------
module elevator_car_controller_tb;
    import ecc_pkg::*;

    localparam int NUM_FLOORS    = NUM_FLOORS_DEF;
    localparam int TIMER_BITS    = TIMER_BITS_DEF;
    localparam int SETTLE_CYCLES = NUM_FLOORS + 8;   // longest beat plus margin
    localparam int DRAIN_LIMIT   = 2000;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int MAX_REPORTS   = 10;

    // Index 3 decodes to no register; write it once to show it is ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        JOB_BEAT,       // one input beat
        JOB_WRITE,      // one register write, only once the car is idle
        JOB_SETTLE      // hold the sender until every report is in, then pause
    } t_job_kind;

    typedef struct {
        t_job_kind          kind;
        t_op                op;
        logic [FLOOR_W-1:0] call;
        logic [MASK_W-1:0]  mask;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]   reg_data;
        int                 idle_pct;
    } t_job;

    typedef struct packed {
        logic [MODE_W-1:0]  state;
        logic [FLOOR_W-1:0] floor;
        logic               up;
        logic               down;
        logic [LAMP_W-1:0]  lamps;
        logic               door;
    } t_car_report;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    t_op                  i_operation   = OP_TICK;
    logic [FLOOR_W-1:0]   i_call_floor  = '0;
    logic [MASK_W-1:0]    i_button_mask = '0;
    logic                 o_result_valid;
    logic [MODE_W-1:0]    o_car_state;
    logic [FLOOR_W-1:0]   o_floor_now;
    logic                 o_up_lamp;
    logic                 o_down_lamp;
    logic [LAMP_W-1:0]    o_floor_lamps;
    logic                 o_door_open;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    elevator_car_controller #(
        .NUM_FLOORS (NUM_FLOORS),
        .TIMER_BITS (TIMER_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_call_floor   (i_call_floor),
        .i_button_mask  (i_button_mask),
        .o_result_valid (o_result_valid),
        .o_car_state    (o_car_state),
        .o_floor_now    (o_floor_now),
        .o_up_lamp      (o_up_lamp),
        .o_down_lamp    (o_down_lamp),
        .o_floor_lamps  (o_floor_lamps),
        .o_door_open    (o_door_open),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns period: high half, then low half
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Car model: registers and state as they stand after every accepted beat
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]      move_ticks = MOVE_TIME_RST;
    logic [CFG_W-1:0]      door_ticks = DOOR_TIME_RST;
    logic [FLOOR_W-1:0]    park_floor = FLOOR_W'(HOME_RST_DEF);

    t_car_mode             car_mode   = MODE_STOPPED;
    logic [FLOOR_W-1:0]    floor_at   = FLOOR_W'(HOME_RST_DEF);
    logic [FLOOR_W-1:0]    aim_floor  = FLOOR_W'(HOME_RST_DEF);
    logic [FLOOR_W-1:0]    stops [NUM_FLOORS] = '{default: FLOOR_W'(HOME_RST_DEF)};
    logic [TIMER_BITS-1:0] travel_left = '0;
    logic [TIMER_BITS-1:0] door_left   = '0;
    logic [1:0]            dir_lamps   = '0;
    logic [LAMP_W-1:0]     indicator   = '0;
    logic                  door_flag   = 1'b0;

    // Stimulus script and reports still owed by the car
    t_job        pending_jobs [$];
    t_car_report due_reports  [$];
    int          sender_idle_pct = 0;
    int          mismatch_count  = 0;
    int          settle_wait     = 0;
    bit          beat_taken      = 1'b0;
    bit          write_taken     = 1'b0;

    // One-hot lamp; floors past the lamp field light nothing.
    function automatic logic [LAMP_W-1:0] lamp_of(input logic [FLOOR_W-1:0] f);
        return (f >= 1 && f <= LAMP_W) ? (LAMP_W'(1) << (f - 1)) : '0;
    endfunction

    // Move one floor once the travel timer has run out, and clear the stops
    // that the new floor satisfies.
    task automatic arrive_at_floor(input bit going_up);
        bit hit;
        hit       = 1'b0;
        floor_at  = going_up ? floor_at + 1'b1 : floor_at - 1'b1;
        dir_lamps = going_up ? 2'b01 : 2'b10;
        indicator = lamp_of(floor_at);
        for (int i = 0; i < NUM_FLOORS; i++) begin
            if (stops[i] == floor_at) begin
                stops[i] = park_floor;
                hit      = 1'b1;
            end
        end
        if (floor_at == aim_floor) begin
            car_mode = MODE_OPENING;
        end else begin
            if (hit) begin
                car_mode = MODE_OPENING;
            end
            travel_left = move_ticks;
        end
    endtask

    // Apply one beat to the car model and return the report it must produce.
    task automatic advance_car(input t_op op, input logic [FLOOR_W-1:0] call,
                               input logic [MASK_W-1:0] mask, output t_car_report rep);
        case (op)
            OP_TICK: begin
                if (travel_left != 0) travel_left = travel_left - 1'b1;
                if (door_left != 0)   door_left   = door_left - 1'b1;
            end
            OP_STEP: begin
                case (car_mode)
                    MODE_RISING: begin
                        if (travel_left == 0) arrive_at_floor(1'b1);
                    end
                    MODE_FALLING: begin
                        if (travel_left == 0) arrive_at_floor(1'b0);
                    end
                    MODE_OPENING: begin
                        door_flag = 1'b1;
                        if (door_left == 0) begin
                            car_mode  = MODE_CLOSING;
                            door_left = door_ticks;
                        end
                    end
                    MODE_CLOSING: begin
                        if (door_left == 0) begin
                            car_mode  = MODE_STOPPED;
                            door_flag = 1'b0;
                        end
                    end
                    default: begin
                        // Empty slots read as the parking floor, so an idle car
                        // heads home: look up first, then down.
                        for (int i = 0; i < NUM_FLOORS; i++) begin
                            if (stops[i] > aim_floor) aim_floor = stops[i];
                        end
                        if (aim_floor > floor_at) begin
                            car_mode    = MODE_RISING;
                            travel_left = move_ticks;
                        end else begin
                            for (int i = 0; i < NUM_FLOORS; i++) begin
                                if (stops[i] < aim_floor) aim_floor = stops[i];
                            end
                            if (aim_floor < floor_at) begin
                                car_mode    = MODE_FALLING;
                                travel_left = move_ticks;
                            end else begin
                                car_mode  = MODE_STOPPED;
                                dir_lamps = 2'b00;
                                indicator = lamp_of(floor_at);
                            end
                        end
                    end
                endcase
            end
            OP_CAB: begin
                // Only an empty slot takes a button; mask bits past the top
                // floor have no slot.
                for (int i = 0; i < NUM_FLOORS && i < MASK_W; i++) begin
                    if (mask[i] && stops[i] == park_floor) stops[i] = FLOOR_W'(i + 1);
                end
            end
            default: begin
                // Hall call: out-of-range floors are dropped; a call here
                // only opens the doors.
                if (call >= 1 && call <= NUM_FLOORS) begin
                    if (call != floor_at) stops[call - 1] = call;
                    car_mode = MODE_OPENING;
                end
            end
        endcase
        rep = '{state: car_mode, floor: floor_at, up: dir_lamps[0], down: dir_lamps[1],
                lamps: indicator, door: door_flag};
    endtask

    task automatic note_mismatch(input string what, input t_car_report want,
                                 input t_car_report got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns %s: expected mode=%0d floor=%0d up=%b down=%b lamps=%b door=%b",
                     $time, what, want.state, want.floor, want.up, want.down,
                     want.lamps, want.door);
            $display("%0t ns %s:   actual mode=%0d floor=%0d up=%b down=%b lamps=%b door=%b",
                     $time, what, got.state, got.floor, got.up, got.down,
                     got.lamps, got.door);
        end
    endtask

    // ------------------------------------------------------------------------
    // Script builders
    // ------------------------------------------------------------------------
    task automatic add_beat(input t_op op, input logic [FLOOR_W-1:0] call,
                            input logic [MASK_W-1:0] mask);
        t_job j;
        j          = '{default: '0, kind: JOB_BEAT, op: OP_TICK};
        j.op       = op;
        j.call     = call;
        j.mask     = mask;
        j.idle_pct = sender_idle_pct;
        pending_jobs.push_back(j);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_job j;
        j          = '{default: '0, kind: JOB_WRITE, op: OP_TICK};
        j.op       = OP_TICK;
        j.reg_idx  = idx;
        j.reg_data = data;
        pending_jobs.push_back(j);
    endtask

    // Drain the car, then load all three registers.
    task automatic add_settings(input logic [CFG_W-1:0] mv, input logic [CFG_W-1:0] dr,
                                input logic [CFG_W-1:0] hm);
        t_job j;
        j      = '{default: '0, kind: JOB_SETTLE, op: OP_TICK};
        j.op   = OP_TICK;
        pending_jobs.push_back(j);
        add_write(CFG_MOVE_TIME, mv);
        add_write(CFG_DOOR_TIME, dr);
        add_write(CFG_HOME, hm);
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge, one update per signal
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_beats
        t_job job;
        logic nxt_start;
        logic nxt_cfg_valid;
        nxt_start     = start;
        nxt_cfg_valid = i_cfg_valid;
        // Drop what the last rising edge took.
        if (start && beat_taken)        nxt_start     = 1'b0;
        if (i_cfg_valid && write_taken) nxt_cfg_valid = 1'b0;
        if (i_rst_n && !nxt_start && !nxt_cfg_valid && pending_jobs.size() != 0) begin
            job = pending_jobs[0];
            case (job.kind)
                JOB_BEAT: begin
                    // Offer the next beat even while busy; it waits on start.
                    if ($urandom_range(99) >= job.idle_pct) begin
                        nxt_start     = 1'b1;
                        i_operation   <= job.op;
                        i_call_floor  <= job.call;
                        i_button_mask <= job.mask;
                        void'(pending_jobs.pop_front());
                    end
                end
                JOB_WRITE: begin
                    if (due_reports.size() == 0 && !busy) begin
                        nxt_cfg_valid = 1'b1;
                        i_cfg_index   <= job.reg_idx;
                        i_cfg_data    <= job.reg_data;
                        void'(pending_jobs.pop_front());
                    end
                end
                default: begin
                    if (due_reports.size() == 0 && !busy) begin
                        if (settle_wait >= SETTLE_CYCLES) begin
                            settle_wait = 0;
                            void'(pending_jobs.pop_front());
                        end else begin
                            settle_wait++;
                        end
                    end else begin
                        settle_wait = 0;
                    end
                end
            endcase
        end
        start       <= nxt_start;
        i_cfg_valid <= nxt_cfg_valid;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge, check reports, then predict
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_car
        t_car_report seen;
        t_car_report want;
        logic [FLOOR_W-1:0] hm;
        beat_taken  = 1'b0;
        write_taken = 1'b0;
        if (i_rst_n) begin
            // A report and a new beat can share an edge; check the report first.
            if (o_result_valid) begin
                seen = '{state: o_car_state, floor: o_floor_now, up: o_up_lamp,
                         down: o_down_lamp, lamps: o_floor_lamps, door: o_door_open};
                if (due_reports.size() == 0) begin
                    note_mismatch("report with no beat pending", '0, seen);
                end else begin
                    want = due_reports.pop_front();
                    if (seen !== want) note_mismatch("report mismatch", want, seen);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_taken = 1'b1;
                case (i_cfg_index)
                    CFG_MOVE_TIME: move_ticks = i_cfg_data;
                    CFG_DOOR_TIME: door_ticks = i_cfg_data;
                    CFG_HOME: begin
                        // Clamp the parking floor into 1..NUM_FLOORS.
                        hm = i_cfg_data[FLOOR_W-1:0];
                        if (hm < 1)          hm = FLOOR_W'(1);
                        if (hm > NUM_FLOORS) hm = FLOOR_W'(NUM_FLOORS);
                        park_floor = hm;
                    end
                    default: ;
                endcase
            end
            if (start && !busy) begin
                beat_taken = 1'b1;
                advance_car(t_op'(i_operation), i_call_floor, i_button_mask, want);
                due_reports.push_back(want);
            end
        end
    end

    // Hard stop if the car hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Script: directed beats, then random phases under different settings
    // ------------------------------------------------------------------------
    initial begin : run_script
        int n_beats;
        int pick;
        int wait_cycles;
        logic [FLOOR_W-1:0] hall;
        logic [MASK_W-1:0]  buttons;

        // Reset settings: car parked at floor 3, long timers. Keep clear of
        // any step that would load a long door time.
        sender_idle_pct = 0;
        add_beat(OP_STEP, 4'd0, 10'h000);
        add_beat(OP_TICK, 4'd0, 10'h000);
        add_beat(OP_CAB,  4'd0, 10'h000);
        add_beat(OP_CAB,  4'd0, 10'h3FF);
        add_beat(OP_CALL, 4'd0, 10'h000);     // floor 0: dropped
        add_beat(OP_CALL, 4'd15, 10'h000);    // past the top: dropped
        add_beat(OP_CALL, 4'd11, 10'h000);
        add_beat(OP_CALL, 4'd3, 10'h000);     // at the car: doors only
        add_beat(OP_CAB,  4'd0, 10'h3FF);     // every slot already taken

        // Zero timers end each wait at the next step; home 0 clamps to 1.
        add_settings(16'd0, 16'd0, 16'h0000);
        add_write(CFG_SPARE, 16'hFFFF);
        repeat (7) add_beat(OP_STEP, 4'd0, 10'h000);
        add_beat(OP_CALL, 4'd10, 10'h000);
        add_beat(OP_TICK, 4'd0, 10'h000);
        repeat (3) add_beat(OP_STEP, 4'd0, 10'h000);
        add_beat(OP_CALL, 4'd1, 10'h000);
        add_beat(OP_CAB,  4'd0, 10'h155);
        add_beat(OP_STEP, 4'd0, 10'h000);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       add_settings(16'd2, 16'd1, 16'd3);
                1:       add_settings(16'd0, 16'd0, 16'd10);
                2:       add_settings(16'd1, 16'd2, 16'h0000);
                3:       add_settings(16'd3, 16'd0, 16'hFFF5);
                4:       add_settings(16'($urandom_range(6)), 16'($urandom_range(6)),
                                      16'($urandom));
                5:       add_settings(16'd1, 16'd1, 16'd1);
                6:       add_settings(16'd4, 16'd3, 16'h000F);
                // Longest timers last: the car barely moves after this.
                default: add_settings(16'hFFFF, 16'hFFFF, 16'd7);
            endcase
            sender_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 69 : 37;
            n_beats         = (p == 7) ? 40 : 85;
            repeat (n_beats) begin
                pick = $urandom_range(99);
                hall = ($urandom_range(99) < 85) ? FLOOR_W'($urandom_range(NUM_FLOORS, 1))
                                                 : FLOOR_W'($urandom_range(15));
                buttons = ($urandom_range(1) != 0)
                          ? MASK_W'(1) << $urandom_range(MASK_W - 1)
                          : MASK_W'($urandom);
                // Mostly ticks and steps so timers expire and the car travels.
                if (pick < 42)      add_beat(OP_TICK, hall, buttons);
                else if (pick < 78) add_beat(OP_STEP, hall, buttons);
                else if (pick < 89) add_beat(OP_CAB, hall, buttons);
                else                add_beat(OP_CALL, hall, buttons);
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_jobs.size() != 0 || start || i_cfg_valid) @(posedge i_clk);
        wait_cycles = 0;
        while (due_reports.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_reports.size() != 0) begin
            $display("%0d reports never arrived", due_reports.size());
            mismatch_count += due_reports.size();
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
